/* rtl/acp_pkg.sv */
// Shared types, codes and constants of the channel packer.
package acp_pkg;

  localparam int OFFSET_W      = 16;  // word offsets wrap modulo 2**OFFSET_W
  localparam int ADDR_W        = 12;
  localparam int FIELD_W       = 10;
  localparam int TIME_W        = 11;
  localparam int PAYLOAD_W     = 3 * FIELD_W;

  localparam logic [TIME_W-1:0] TIME_BIN_LIMIT_RST = 11'd1000;
  localparam logic [TIME_W-1:0] PREV_START_RST     = 11'h7FF;
  localparam logic [11:0]       MAX_TENBIT_WORDS   = 12'd767;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_OPEN   = 2'd0,
    FUNC_BUNCH  = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_CLOSE  = 2'd3
  } func_e;

  // Next 10-bit field position in the word being built.
  typedef enum logic [1:0] {
    SLOT_THIRD  = 2'd0,
    SLOT_SECOND = 2'd1,
    SLOT_FIRST  = 2'd2
  } slot_e;

  typedef struct packed {
    func_e               func;
    logic [ADDR_W-1:0]   hw_address;
    logic                start_event;
    logic [TIME_W-1:0]   bunch_first_time;
    logic [FIELD_W-1:0]  bunch_length;
    logic [FIELD_W-1:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] word_offset;
    logic [31:0]         word_data;
    logic                is_header;
    logic                channel_truncated;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [1:0]   count;
    result_t [1:0] res;
  } res_bundle_t;

  typedef struct packed {
    logic not_empty;
    logic room_two;
  } fifo_stat_t;

  typedef struct packed {
    slot_e                slot;
    logic [PAYLOAD_W-1:0] word;
    logic [OFFSET_W-1:0]  woff;
    logic [OFFSET_W-1:0]  cnt;
  } pack_st_t;

  typedef struct packed {
    pack_st_t st;
    logic     emit;
  } pack_res_t;

  // Place one 10-bit field into the word under construction.
  function automatic pack_res_t pack10(pack_st_t s, logic [FIELD_W-1:0] v);
    pack_res_t r;
    r.st   = s;
    r.emit = 1'b0;
    case (s.slot)
      SLOT_FIRST: begin
        r.st.woff = s.cnt;
        r.st.cnt  = s.cnt + OFFSET_W'(1);
        r.st.word = {v, {(2*FIELD_W){1'b0}}};
        r.st.slot = SLOT_SECOND;
      end
      SLOT_SECOND: begin
        r.st.word[2*FIELD_W-1:FIELD_W] = v;
        r.st.slot = SLOT_THIRD;
      end
      SLOT_THIRD: begin
        r.st.word[FIELD_W-1:0] = v;
        r.st.slot = SLOT_FIRST;
        r.emit    = 1'b1;
      end
      default: r.st.slot = SLOT_FIRST;
    endcase
    return r;
  endfunction

  function automatic result_t payload_word(logic [OFFSET_W-1:0] off,
                                           logic [PAYLOAD_W-1:0] word);
    result_t r;
    r.word_offset       = off;
    r.word_data         = {2'b00, word};
    r.is_header         = 1'b0;
    r.channel_truncated = 1'b0;
    r.last              = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/acp_core.sv */
// Channel state, bunch checks and field packing for one accepted transfer.
module acp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [acp_pkg::TIME_W-1:0]  cfg_wdata_i,
  input  logic                        in_fire_i,
  input  acp_pkg::in_item_t           item_i,
  output acp_pkg::res_bundle_t        res_o
);
  import acp_pkg::*;

  logic [TIME_W-1:0]   limit_q;
  pack_st_t            ps_q, ps_d;
  logic [OFFSET_W-1:0] hdr_slot_q, hdr_slot_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [FIELD_W-1:0]  tenbit_q, tenbit_d;
  logic [TIME_W-1:0]   prev_q, prev_d;
  logic [FIELD_W-1:0]  left_q, left_d;
  logic                stopped_q, stopped_d;

  logic [11:0] end_time;
  logic [11:0] total;
  logic        bad_bunch;
  result_t     hdr_word;

  // End time and total only matter once the start time is known nonnegative.
  assign end_time = {2'b00, item_i.bunch_first_time[FIELD_W-1:0]}
                  + {2'b00, item_i.bunch_length} - 12'd1;
  assign total    = {2'b00, tenbit_q} + {2'b00, item_i.bunch_length} + 12'd2;
  assign bad_bunch = item_i.bunch_first_time[TIME_W-1]
                   || (end_time >= {1'b0, limit_q})
                   || (end_time >= {1'b0, prev_q})
                   || (total > MAX_TENBIT_WORDS);

  always_comb begin
    hdr_word.word_offset       = hdr_slot_q;
    hdr_word.word_data         = {2'b01, 4'b0000, tenbit_q, 4'b0000, addr_q};
    hdr_word.is_header         = 1'b1;
    hdr_word.channel_truncated = stopped_q;
    hdr_word.last              = 1'b1;
  end

  always_comb begin : next_state
    pack_res_t           p1;
    pack_res_t           p2;
    logic [OFFSET_W-1:0] base;
    ps_d       = ps_q;
    hdr_slot_d = hdr_slot_q;
    addr_d     = addr_q;
    tenbit_d   = tenbit_q;
    prev_d     = prev_q;
    left_d     = left_q;
    stopped_d  = stopped_q;
    res_o      = '0;
    p1         = '0;
    p2         = '0;
    base       = '0;
    if (in_fire_i) begin
      case (item_i.func)
        FUNC_OPEN: begin
          base       = item_i.start_event ? '0 : ps_q.cnt;
          hdr_slot_d = base;
          ps_d.cnt   = base + OFFSET_W'(1);
          ps_d.slot  = SLOT_FIRST;
          ps_d.word  = '0;
          addr_d     = item_i.hw_address;
          tenbit_d   = '0;
          prev_d     = PREV_START_RST;
          left_d     = '0;
          stopped_d  = 1'b0;
        end
        FUNC_BUNCH: begin
          if (!stopped_q && left_q == '0 && item_i.bunch_length != '0) begin
            if (bad_bunch) begin
              stopped_d = 1'b1;
            end else begin
              prev_d   = item_i.bunch_first_time;
              tenbit_d = total[FIELD_W-1:0];
              p1       = pack10(ps_q, item_i.bunch_length + FIELD_W'(2));
              p2       = pack10(p1.st, end_time[FIELD_W-1:0]);
              ps_d     = p2.st;
              left_d   = item_i.bunch_length;
              // At most one of the two fields completes a word.
              if (p1.emit) begin
                res_o.count  = 2'd1;
                res_o.res[0] = payload_word(p1.st.woff, p1.st.word);
              end else if (p2.emit) begin
                res_o.count  = 2'd1;
                res_o.res[0] = payload_word(p2.st.woff, p2.st.word);
              end
              res_o.res[0].last = 1'b1;
            end
          end
        end
        FUNC_SAMPLE: begin
          if (!stopped_q && left_q != '0) begin
            p1     = pack10(ps_q, item_i.sample_value);
            ps_d   = p1.st;
            left_d = left_q - FIELD_W'(1);
            if (p1.emit) begin
              res_o.count       = 2'd1;
              res_o.res[0]      = payload_word(p1.st.woff, p1.st.word);
              res_o.res[0].last = 1'b1;
            end
          end
        end
        FUNC_CLOSE: begin
          left_d = '0;
          if (ps_q.slot != SLOT_FIRST) begin
            // Flush the unfinished word ahead of the header.
            ps_d.slot    = SLOT_FIRST;
            res_o.count  = 2'd2;
            res_o.res[0] = payload_word(ps_q.woff, ps_q.word);
            res_o.res[1] = hdr_word;
          end else begin
            res_o.count  = 2'd1;
            res_o.res[0] = hdr_word;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= TIME_BIN_LIMIT_RST;
      ps_q.slot  <= SLOT_FIRST;
      ps_q.word  <= '0;
      ps_q.woff  <= '0;
      ps_q.cnt   <= '0;
      hdr_slot_q <= '0;
      addr_q     <= '0;
      tenbit_q   <= '0;
      prev_q     <= PREV_START_RST;
      left_q     <= '0;
      stopped_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      ps_q       <= ps_d;
      hdr_slot_q <= hdr_slot_d;
      addr_q     <= addr_d;
      tenbit_q   <= tenbit_d;
      prev_q     <= prev_d;
      left_q     <= left_d;
      stopped_q  <= stopped_d;
    end
  end

endmodule

/* rtl/acp_out_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle while pop_i is set.
module acp_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acp_pkg::res_bundle_t push_i,
  input  logic                 pop_i,
  output acp_pkg::result_t     head_o,
  output acp_pkg::fifo_stat_t  stat_o
);
  import acp_pkg::*;

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.room_two  = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop_i);
    count_d  = count_q + FIFO_CNT_W'(push_i.count) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/altro_channel_packer.sv */
// Results of an accepted transfer are registered in the output queue and offered on the master side.
// Throughput: one input transfer per cycle while not stalled; results leave one per cycle
// while m_axis_tready is high, from a four-entry queue, so an input causing two results
// needs two output transfers. Input is stalled while the queue holds more than two results.
// Reset (rst_ni low, asynchronous): queue empty, channel state cleared,
// time bin limit 1000, no clearing pass.
module altro_channel_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,     // time_bin_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hw_address[11:0], start_event[12], bunch_first_time[23:13],
  // bunch_length[33:24], sample_value[43:34], zero fill[47:44]
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,    // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // word_offset[15:0], word_data[47:16]
  output logic [1:0]  m_axis_tuser,    // is_header[0], channel_truncated[1]
  output logic        m_axis_tlast     // last
);
  import acp_pkg::*;

  in_item_t    item;
  res_bundle_t results;
  result_t     head;
  fifo_stat_t  stat;
  logic        in_fire;
  logic        out_fire;

  always_comb begin
    item.func             = func_e'(s_axis_tuser);
    item.hw_address       = s_axis_tdata[11:0];
    item.start_event      = s_axis_tdata[12];
    item.bunch_first_time = s_axis_tdata[23:13];
    item.bunch_length     = s_axis_tdata[33:24];
    item.sample_value     = s_axis_tdata[43:34];
  end

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign out_fire = m_axis_tvalid & m_axis_tready;

  acp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .item_i      (item),
    .res_o       (results)
  );

  acp_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (results),
    .pop_i  (out_fire),
    .head_o (head),
    .stat_o (stat)
  );

  assign s_axis_tready = stat.room_two;
  assign m_axis_tvalid = stat.not_empty;
  assign m_axis_tdata  = {head.word_data, head.word_offset};
  assign m_axis_tuser  = {head.channel_truncated, head.is_header};
  assign m_axis_tlast  = head.last;

endmodule

/* rtl/acp_checker.sv */
// Port-level checks of the channel packer, bound to the top level.
module acp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A header word carries bit 30 set and bit 31 clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:46] == 2'b01)
    else $error("header word without header marker");

  // Payload words keep the top two bits clear and never flag truncation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[47:46] == 2'b00 && !m_axis_tuser[1])
    else $error("malformed payload word");

  // The header is always the final result of a close.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("header word without tlast");

  // A stalled output transfer holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready == 1'b0 |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  // The input only stalls while results are waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

endmodule

bind altro_channel_packer acp_checker u_acp_checker (.*);

/* dv/acp_checker.sv */
// Scoreboard for the channel packer: predicts the result words and compares them.
module acp_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import acp_pkg::*;

  logic [TIME_W-1:0]    time_limit;
  logic [OFFSET_W-1:0]  event_cnt;
  logic [OFFSET_W-1:0]  hdr_slot;
  logic [OFFSET_W-1:0]  word_off;
  logic [ADDR_W-1:0]    chan_addr;
  logic [FIELD_W-1:0]   tenbit_cnt;
  logic [FIELD_W-1:0]   samples_left;
  logic [TIME_W-1:0]    prev_start;
  slot_e                slot;
  logic [PAYLOAD_W-1:0] word;
  logic                 stopped;
  result_t              expected_words[$];
  int                   fails;
  int                   checked;

  task automatic push_word(input logic [OFFSET_W-1:0] off, input logic [31:0] data,
                           input logic hdr, input logic trunc);
    result_t r;
    r.word_offset       = off;
    r.word_data         = data;
    r.is_header         = hdr;
    r.channel_truncated = trunc;
    r.last              = 1'b0;
    expected_words.push_back(r);
  endtask

  task automatic pack_field(input logic [FIELD_W-1:0] v);
    case (slot)
      SLOT_FIRST: begin
        word_off  = event_cnt;
        event_cnt = event_cnt + OFFSET_W'(1);
        word      = {v, {(2*FIELD_W){1'b0}}};
        slot      = SLOT_SECOND;
      end
      SLOT_SECOND: begin
        word[2*FIELD_W-1:FIELD_W] = v;
        slot = SLOT_THIRD;
      end
      default: begin
        word[FIELD_W-1:0] = v;
        slot = SLOT_FIRST;
        push_word(word_off, {2'b00, word}, 1'b0, 1'b0);
      end
    endcase
  endtask

  task automatic predict_transfer(input func_e f, input logic [47:0] d);
    logic [FIELD_W-1:0] len;
    int                 first_t;
    int                 end_t;
    int                 n_before;
    result_t            tail;
    n_before = expected_words.size();
    len      = d[33:24];
    case (f)
      FUNC_OPEN: begin
        if (d[12]) event_cnt = '0;
        hdr_slot     = event_cnt;
        event_cnt    = event_cnt + OFFSET_W'(1);
        chan_addr    = d[11:0];
        tenbit_cnt   = '0;
        prev_start   = PREV_START_RST;
        slot         = SLOT_FIRST;
        word         = '0;
        samples_left = '0;
        stopped      = 1'b0;
      end
      FUNC_BUNCH: begin
        first_t = int'($signed(d[23:13]));
        end_t   = first_t + int'(len) - 1;
        // Ignore on a stopped channel, with samples pending, or with zero length.
        if (stopped || samples_left != '0 || len == '0) begin
        end else if (first_t < 0 || end_t >= int'(time_limit) ||
                     end_t >= int'(prev_start) ||
                     int'(tenbit_cnt) + int'(len) + 2 > int'(MAX_TENBIT_WORDS)) begin
          stopped = 1'b1;
        end else begin
          prev_start = TIME_W'(first_t);
          tenbit_cnt = tenbit_cnt + len + FIELD_W'(2);
          pack_field(len + FIELD_W'(2));
          pack_field(FIELD_W'(end_t));
          samples_left = len;
        end
      end
      FUNC_SAMPLE: begin
        if (!stopped && samples_left != '0) begin
          pack_field(d[43:34]);
          samples_left = samples_left - FIELD_W'(1);
        end
      end
      default: begin
        // Flush the unfinished word, then the channel header.
        if (slot != SLOT_FIRST) begin
          push_word(word_off, {2'b00, word}, 1'b0, 1'b0);
          slot = SLOT_FIRST;
        end
        samples_left = '0;
        push_word(hdr_slot, {2'b01, 4'b0000, tenbit_cnt, 4'b0000, chan_addr}, 1'b1, stopped);
      end
    endcase
    if (expected_words.size() > n_before) begin
      tail      = expected_words[expected_words.size() - 1];
      tail.last = 1'b1;
      expected_words[expected_words.size() - 1] = tail;
    end
  endtask

  task automatic check_word();
    result_t want;
    result_t got;
    got.word_offset       = m_axis_tdata[15:0];
    got.word_data         = m_axis_tdata[47:16];
    got.is_header         = m_axis_tuser[0];
    got.channel_truncated = m_axis_tuser[1];
    got.last              = m_axis_tlast;
    checked++;
    if (expected_words.size() == 0) begin
      $error("unexpected result: word_offset %h word_data %h", got.word_offset, got.word_data);
      fails++;
    end else begin
      want = expected_words.pop_front();
      if (got.word_offset != want.word_offset) begin
        $error("word_offset: expected %h, actual %h", want.word_offset, got.word_offset);
        fails++;
      end
      if (got.word_data != want.word_data) begin
        $error("word_data: expected %h, actual %h", want.word_data, got.word_data);
        fails++;
      end
      if (got.is_header != want.is_header) begin
        $error("is_header: expected %b, actual %b", want.is_header, got.is_header);
        fails++;
      end
      if (got.channel_truncated != want.channel_truncated) begin
        $error("channel_truncated: expected %b, actual %b",
               want.channel_truncated, got.channel_truncated);
        fails++;
      end
      if (got.last != want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_limit   = TIME_BIN_LIMIT_RST;
      event_cnt    = '0;
      hdr_slot     = '0;
      word_off     = '0;
      chan_addr    = '0;
      tenbit_cnt   = '0;
      samples_left = '0;
      prev_start   = PREV_START_RST;
      slot         = SLOT_FIRST;
      word         = '0;
      stopped      = 1'b0;
      expected_words.delete();
      fails        = 0;
      checked      = 0;
    end else begin
      if (cfg_we_i) time_limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) predict_transfer(func_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_word();
    end
    pending_o    <= expected_words.size();
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

/* dv/testbench.sv */
// Top of the channel packer testbench: stimulus, stalls, watchdog and verdict.
module testbench;
  import acp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_data    = '0;
  logic [1:0]  s_user    = '0;
  logic        m_axis_tvalid;
  logic        m_ready   = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int fail_count;
  int pending;
  int checked;
  int n_func[4];
  int cur_limit   = 1000;
  bit tx_calm     = 1'b0;
  bit tx_rush     = 1'b0;
  bit rx_calm     = 1'b0;
  bit rx_hold_req = 1'b0;

  altro_channel_packer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  acp_scoreboard u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int min_of(int a, int b);
    return (a < b) ? a : b;
  endfunction

  task automatic send_item(input func_e f, input logic [11:0] addr, input logic se,
                           input logic [10:0] first, input logic [9:0] len,
                           input logic [9:0] smp);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    gap = (tx_calm || tx_rush) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= f;
    s_data  <= {4'b0000, smp, len, first, se, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    n_func[int'(f)]++;
  endtask

  task automatic do_open(input logic [11:0] addr, input logic se);
    send_item(FUNC_OPEN, addr, se, 11'($urandom), 10'($urandom), 10'($urandom));
  endtask

  task automatic do_bunch(input int first, input int len);
    send_item(FUNC_BUNCH, 12'($urandom), 1'($urandom), 11'(first), 10'(len), 10'($urandom));
  endtask

  task automatic do_sample(input logic [9:0] v);
    send_item(FUNC_SAMPLE, 12'($urandom), 1'($urandom), 11'($urandom), 10'($urandom), v);
  endtask

  task automatic do_close();
    send_item(FUNC_CLOSE, 12'($urandom), 1'($urandom), 11'($urandom), 10'($urandom),
              10'($urandom));
  endtask

  task automatic do_noise();
    send_item(func_e'($urandom_range(0, 3)), 12'($urandom), 1'($urandom), 11'($urandom),
              10'($urandom), 10'($urandom));
  endtask

  // Drop valid and wait until every predicted word has been delivered.
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= 11'(v);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    cur_limit = v;
  endtask

  // One channel: open, a few bunches in descending time order, mostly a close.
  task automatic gen_channel(input int max_len);
    int ceil_t;
    int n_bunch;
    int len;
    int top;
    int last_t;
    int first;
    int tenbits;
    int n_smp;
    do_open(12'($urandom), $urandom_range(0, 3) == 0);
    ceil_t  = cur_limit;
    tenbits = 0;
    n_bunch = $urandom_range(0, 4);
    for (int b = 0; b < n_bunch; b++) begin
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0: do_bunch($urandom_range(0, 1023), 0);
          1: do_bunch(-int'($urandom_range(1, 1024)), $urandom_range(1, 1023));
          2: begin
            // end lands on or past the previous start or the limit
            first = $urandom_range(0, ceil_t);
            do_bunch(first, min_of(ceil_t - first + 1 + $urandom_range(0, 3), 1023));
          end
          default: do_bunch(0, min_of(766 - tenbits + $urandom_range(0, 3), 1023));
        endcase
      end else begin
        top = min_of(min_of(max_len, ceil_t), 765 - tenbits);
        if (top < 1) break;
        len    = $urandom_range(1, top);
        last_t = $urandom_range(len - 1, ceil_t - 1);
        first  = last_t - len + 1;
        do_bunch(first, len);
        ceil_t  = first;
        tenbits = tenbits + len + 2;
        n_smp   = len;
        if ($urandom_range(0, 9) == 0) n_smp = $urandom_range(0, len + 3);
        repeat (n_smp) do_sample(10'($urandom));
      end
    end
    case ($urandom_range(0, 19))
      0: ;  // leave it open, the next open drops it
      1: begin
        do_close();
        do_close();
      end
      default: do_close();
    endcase
  endtask

  // Receiver: random stall before each transfer, and a long hold-off on request.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      if (rx_hold_req) begin
        m_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_hold_req = 1'b0;
        stall = 0;
      end else begin
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        stall = rx_calm ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) idle = 0;
      else idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase_start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: close with nothing open, then the bunch rules one by one.
    do_close();
    do_open(12'hFFF, 1'b1);
    do_bunch(5, 2);
    do_sample(10'h3FF);
    do_bunch(0, 1);           // samples still pending: ignored
    do_sample(10'h000);
    do_sample(10'h309);       // surplus: ignored
    do_bunch(0, 0);           // zero length: skipped
    do_bunch(2, 2);
    do_sample(10'h155);
    do_sample(10'h2AA);
    do_bunch(1, 3);           // end overlaps the previous start: stop
    do_sample(10'h3FF);       // stopped channel: ignored
    do_close();
    do_open(12'h000, 1'b0);
    do_bunch(0, 765);         // total exactly at the maximum
    do_close();               // abandons all samples, count still 767
    do_open(12'hA5A, 1'b0);
    do_bunch(0, 766);         // total one above the maximum: stop
    do_close();
    do_open(12'h123, 1'b1);
    do_bunch(-1024, 1);       // negative start: stop
    do_open(12'h5A5, 1'b0);   // reopen drops the old channel
    do_bunch(1023, 1);        // end past the time bin limit: stop
    do_close();
    do_close();
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_limit(1024);
        1: write_limit(1);
        4: write_limit(1000);
        default: write_limit($urandom_range(1, 1024));
      endcase
      if (p == 0) begin
        // Fill the output queue while the receiver holds off.
        rx_hold_req = 1'b1;
        tx_rush     = 1'b1;
        do_open(12'($urandom), 1'b0);
        do_bunch(100, 90);
        repeat (90) do_sample(10'($urandom));
        do_close();
        tx_rush = 1'b0;
        wait_drained();
      end
      phase_start = n_func[0] + n_func[1] + n_func[2] + n_func[3];
      while (n_func[0] + n_func[1] + n_func[2] + n_func[3] - phase_start < 240) begin
        if ($urandom_range(0, 9) == 0) do_noise();
        else gen_channel(($urandom_range(0, 29) == 0) ? 200 : 10);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Transfers in: %0d opens, %0d bunch headers, %0d samples, %0d closes",
             n_func[0], n_func[1], n_func[2], n_func[3]);
    $display("Words checked: %0d over time bin limits 1000, 1024, 1 and random, %s",
             checked, "with a long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/acp_pkg.sv
rtl/acp_core.sv
rtl/acp_out_fifo.sv
rtl/altro_channel_packer.sv
rtl/acp_checker.sv
dv/acp_checker.sv
dv/testbench.sv
